FILE: hdl/hflr_pkg.sv
package hflr_pkg;

  localparam int ENTRIES_DEFAULT = 128;

  localparam int KIND_W   = 2;
  localparam int HANDLE_W = 7;
  localparam int OWNER_W  = 32;
  localparam int REF_W    = 48;
  localparam int STATUS_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_REGISTER  = 2'd0,
    KIND_RELEASE   = 2'd1,
    KIND_LOOKUP_H  = 2'd2,
    KIND_LOOKUP_OW = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_NO_FREE     = 3'd1,
    ST_BAD_HANDLE  = 3'd2,
    ST_NOT_OWNER   = 3'd3,
    ST_WRONG_ORDER = 3'd4,
    ST_INTERNAL    = 3'd5,
    ST_DENIED      = 3'd6,
    ST_NOT_FOUND   = 3'd7
  } status_e;

  typedef struct packed {
    status_e               status;
    logic [HANDLE_W-1:0]   handle;
    logic [REF_W-1:0]      vm_ref;
  } result_t;

endpackage

FILE: hdl/hflr_ram.sv
module hflr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/handle_free_list_registry_top.sv
// Handle registry: ENTRIES-1 handles (1 to ENTRIES-1) on a free chain and a used
// chain, all kept in one entry RAM (link, live flag, owner, reference) with a single
// registered read port. After reset the block runs a clearing pass over every entry
// that builds the free chain, and accepts no request until it is done. A register,
// a lookup by handle or a release that is turned down reads its entry and goes from
// S_REG, S_LKH or S_REL to S_EMIT. A release goes on through S_REL_FREE when the
// handle heads the used chain; otherwise it first walks the used chain through
// S_WALK_ISS and S_WALK_CHK, one entry ahead of it at a time. A lookup by owner
// reads one entry a cycle from handle 1 upward and scans at most ENTRIES-1 entries.
// The chain walk and the owner scan are bound by the one RAM read per cycle. One
// request is in flight at a time; a new request is taken while the previous result
// still waits in the output register, and a result that cannot leave holds the block in its last step.
module handle_free_list_registry_top
  import hflr_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // handle[6:0], owner_id[38:7], vm_ref[86:39], access_granted[87]
  input  logic [87:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], handle_out[9:3], vm_ref_out[57:10], zero[63:58]
  output logic [63:0] m_axis_tdata
);

  localparam int IW = $clog2(ENTRIES);
  localparam int RW = IW + 1 + OWNER_W + REF_W;
  localparam int BW = $clog2(ENTRIES + 3);

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_REG      = 4'd2;
  localparam logic [3:0] S_REL      = 4'd3;
  localparam logic [3:0] S_WALK_ISS = 4'd4;
  localparam logic [3:0] S_WALK_CHK = 4'd5;
  localparam logic [3:0] S_REL_FREE = 4'd6;
  localparam logic [3:0] S_LKH      = 4'd7;
  localparam logic [3:0] S_SCAN     = 4'd8;
  localparam logic [3:0] S_EMIT     = 4'd9;

  logic [3:0]          state_q, state_d;
  logic [IW-1:0]       init_q, init_d;
  logic [IW-1:0]       free_head_q, free_head_d;
  logic [IW-1:0]       used_head_q, used_head_d;
  logic [HANDLE_W-1:0] hdl_q, hdl_d;
  logic [OWNER_W-1:0]  own_q, own_d;
  logic [REF_W-1:0]    ref_q, ref_d;
  logic                gr_q, gr_d;
  logic [IW-1:0]       prev_q, prev_d;
  logic [IW-1:0]       hnext_q, hnext_d;
  logic [BW-1:0]       budget_q, budget_d;
  logic [IW-1:0]       cur_q, cur_d;
  result_t             res_q, res_d;
  logic                out_valid_q, out_valid_d;
  result_t             out_q, out_d;

  logic                we;
  logic [IW-1:0]       waddr, raddr;
  logic [RW-1:0]       wdata, rdata;

  logic [IW-1:0]       rd_next;
  logic                rd_live;
  logic [OWNER_W-1:0]  rd_owner;
  logic [REF_W-1:0]    rd_ref;
  logic [IW-1:0]       h_idx;
  logic                h_bad;

  assign rd_next  = rdata[RW-1 -: IW];
  assign rd_live  = rdata[OWNER_W+REF_W];
  assign rd_owner = rdata[REF_W +: OWNER_W];
  assign rd_ref   = rdata[REF_W-1:0];
  assign h_idx    = IW'(hdl_q);
  assign h_bad    = (hdl_q == '0) || (32'(hdl_q) >= ENTRIES);

  hflr_ram #(
    .WIDTH(RW),
    .DEPTH(ENTRIES)
  ) u_entries (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.vm_ref, out_q.handle, out_q.status};

  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    free_head_d = free_head_q;
    used_head_d = used_head_q;
    hdl_d       = hdl_q;
    own_d       = own_q;
    ref_d       = ref_q;
    gr_d        = gr_q;
    prev_d      = prev_q;
    hnext_d     = hnext_q;
    budget_d    = budget_q;
    cur_d       = cur_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_INIT: begin
        // clearing pass: link i to i+1, entry 0 and the last entry to nil
        we    = 1'b1;
        waddr = init_q;
        wdata = '0;
        if (init_q != '0 && 32'(init_q) != ENTRIES - 1) begin
          wdata[RW-1 -: IW] = init_q + 1'b1;
        end
        init_d = init_q + 1'b1;
        if (32'(init_q) == ENTRIES - 1) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (s_axis_tvalid) begin
          hdl_d  = s_axis_tdata[6:0];
          own_d  = s_axis_tdata[38:7];
          ref_d  = s_axis_tdata[86:39];
          gr_d   = s_axis_tdata[87];
          cur_d  = IW'(1);
          case (kind_e'(s_axis_tuser))
            KIND_REGISTER: begin
              raddr   = free_head_q;
              state_d = S_REG;
            end
            KIND_RELEASE: begin
              raddr   = IW'(s_axis_tdata[6:0]);
              state_d = S_REL;
            end
            KIND_LOOKUP_H: begin
              raddr   = IW'(s_axis_tdata[6:0]);
              state_d = S_LKH;
            end
            default: begin
              raddr   = IW'(1);
              state_d = S_SCAN;
            end
          endcase
        end
      end

      S_REG: begin
        res_d   = '{status: ST_OK, handle: '0, vm_ref: '0};
        state_d = S_EMIT;
        if (free_head_q == '0) begin
          res_d.status = ST_NO_FREE;
        end else if (ref_q == '0) begin
          res_d.status = ST_BAD_HANDLE;
        end else if (own_q == '0 || rd_live || rd_ref != '0
                     || 32'(rd_next) >= ENTRIES) begin
          res_d.status = ST_INTERNAL;
        end else if (gr_q) begin
          we          = 1'b1;
          waddr       = free_head_q;
          wdata       = {used_head_q, 1'b1, own_q, ref_q};
          free_head_d = rd_next;
          used_head_d = free_head_q;
          res_d.handle = HANDLE_W'(free_head_q);
        end else begin
          // denied: the entry goes back to the free head with its old link
          we           = 1'b1;
          waddr        = free_head_q;
          wdata        = {rd_next, 1'b0, {OWNER_W{1'b0}}, {REF_W{1'b0}}};
          res_d.status = ST_DENIED;
        end
      end

      S_REL: begin
        res_d   = '{status: ST_OK, handle: '0, vm_ref: '0};
        state_d = S_EMIT;
        hnext_d = rd_next;
        if (ref_q == '0 || h_bad) begin
          res_d.status = ST_BAD_HANDLE;
        end else if (rd_owner == '0) begin
          res_d.status = ST_WRONG_ORDER;
        end else if (rd_ref != ref_q || rd_owner != own_q) begin
          res_d.status = ST_NOT_OWNER;
        end else if (!rd_live || 32'(rd_next) >= ENTRIES) begin
          res_d.status = ST_INTERNAL;
        end else if (used_head_q == h_idx) begin
          used_head_d = rd_next;
          state_d     = S_REL_FREE;
        end else begin
          prev_d   = used_head_q;
          budget_d = BW'(ENTRIES + 2);
          state_d  = S_WALK_ISS;
        end
      end

      S_WALK_ISS: begin
        if (prev_q == '0 || 32'(prev_q) >= ENTRIES || budget_q == '0) begin
          res_d   = '{status: ST_INTERNAL, handle: '0, vm_ref: '0};
          state_d = S_EMIT;
        end else begin
          raddr    = prev_q;
          budget_d = budget_q - 1'b1;
          state_d  = S_WALK_CHK;
        end
      end

      S_WALK_CHK: begin
        // rdata holds the entry at prev_q
        if (rd_next == h_idx) begin
          we      = 1'b1;
          waddr   = prev_q;
          wdata   = {hnext_q, rdata[RW-IW-1:0]};
          state_d = S_REL_FREE;
        end else if (rd_next == '0 || 32'(rd_next) >= ENTRIES || budget_q == '0) begin
          res_d   = '{status: ST_INTERNAL, handle: '0, vm_ref: '0};
          state_d = S_EMIT;
        end else begin
          raddr    = rd_next;
          prev_d   = rd_next;
          budget_d = budget_q - 1'b1;
        end
      end

      S_REL_FREE: begin
        we          = 1'b1;
        waddr       = h_idx;
        wdata       = {free_head_q, 1'b0, {OWNER_W{1'b0}}, {REF_W{1'b0}}};
        free_head_d = h_idx;
        res_d       = '{status: ST_OK, handle: hdl_q, vm_ref: '0};
        state_d     = S_EMIT;
      end

      S_LKH: begin
        state_d = S_EMIT;
        if (h_bad) begin
          res_d = '{status: ST_BAD_HANDLE, handle: '0, vm_ref: '0};
        end else if (!rd_live || rd_owner == '0) begin
          res_d = '{status: ST_NOT_FOUND, handle: '0, vm_ref: '0};
        end else begin
          res_d = '{status: ST_OK, handle: hdl_q, vm_ref: rd_ref};
        end
      end

      S_SCAN: begin
        // rdata holds the entry at cur_q
        if (own_q != '0 && rd_live && rd_owner == own_q) begin
          res_d   = '{status: ST_OK, handle: HANDLE_W'(cur_q), vm_ref: rd_ref};
          state_d = S_EMIT;
        end else if (own_q == '0 || 32'(cur_q) == ENTRIES - 1) begin
          res_d   = '{status: ST_NOT_FOUND, handle: '0, vm_ref: '0};
          state_d = S_EMIT;
        end else begin
          raddr = cur_q + 1'b1;
          cur_d = cur_q + 1'b1;
        end
      end

      S_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_q      <= '0;
      free_head_q <= IW'(1);
      used_head_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      free_head_q <= free_head_d;
      used_head_q <= used_head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdl_q    <= hdl_d;
    own_q    <= own_d;
    ref_q    <= ref_d;
    gr_q     <= gr_d;
    prev_q   <= prev_d;
    hnext_q  <= hnext_d;
    budget_q <= budget_d;
    cur_q    <= cur_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

endmodule

FILE: dv/handle_free_list_registry_top_tb.sv
`timescale 1ns / 1ps

module handle_free_list_registry_top_tb;
  import hflr_pkg::*;

  localparam int ENTRIES       = ENTRIES_DEFAULT;
  localparam int IDLE_PCT      = 23;
  localparam int RANDOM_ITEMS  = 800;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = ENTRIES + 16;
  localparam int MAX_PRINTS    = 40;
  localparam int NUM_ROWS      = 25;

  localparam logic [OWNER_W-1:0] OWN_MAX = '1;
  localparam logic [REF_W-1:0]   REF_MAX = '1;
  localparam logic [OWNER_W-1:0] OWN_A   = 32'h5A5A_A5A5;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

  typedef struct packed {
    kind_e                kind;
    logic [HANDLE_W-1:0]  hnd;
    logic [OWNER_W-1:0]   own;
    logic [REF_W-1:0]     vr;
    logic                 grant;
    logic                 typed;
    status_e              st;
    logic [HANDLE_W-1:0]  h_out;
    logic [REF_W-1:0]     r_out;
  } row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // handle[6:0], owner_id[38:7], vm_ref[86:39], access_granted[87]
  logic [87:0] s_axis_tdata  = '0;
  // kind[1:0]
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // status[2:0], handle_out[9:3], vm_ref_out[57:10], zero[63:58]
  logic [63:0] m_axis_tdata;

  always #4 clk_i = ~clk_i;

  handle_free_list_registry_top #(
    .ENTRIES(ENTRIES)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // registry image kept by the testbench
  int unsigned        link_of  [ENTRIES];
  logic [OWNER_W-1:0] owner_of [ENTRIES];
  logic [REF_W-1:0]   vmref_of [ENTRIES];
  bit                 live_of  [ENTRIES];
  int unsigned        free_top;
  int unsigned        used_top;

  result_t     result_q [$];
  int          mismatches   = 0;
  int          results_seen = 0;
  int          quiet_cycles = 0;
  bit          idle_en      = 1'b1;

  logic [OWNER_W-1:0] owner_pool [8] = '{32'h1, 32'h2, 32'h3, 32'hFFFF_FFFF,
                                         32'h8000_0000, 32'h0000_BEEF, OWN_A,
                                         32'h7FFF_FFFE};

  row_t directed_rows [NUM_ROWS] = '{
    '{KIND_LOOKUP_H,  7'd1,   32'd0,   48'd0,     1'b0, 1'b1, ST_NOT_FOUND,   7'd0, 48'd0},
    '{KIND_LOOKUP_H,  7'd0,   32'd0,   48'd0,     1'b0, 1'b1, ST_BAD_HANDLE,  7'd0, 48'd0},
    '{KIND_LOOKUP_OW, 7'd0,   32'd0,   48'd0,     1'b0, 1'b1, ST_NOT_FOUND,   7'd0, 48'd0},
    '{KIND_RELEASE,   7'd1,   32'd5,   48'd1,     1'b1, 1'b1, ST_WRONG_ORDER, 7'd0, 48'd0},
    '{KIND_RELEASE,   7'd0,   32'd5,   48'd1,     1'b1, 1'b1, ST_BAD_HANDLE,  7'd0, 48'd0},
    '{KIND_RELEASE,   7'd5,   32'd5,   48'd0,     1'b1, 1'b1, ST_BAD_HANDLE,  7'd0, 48'd0},
    '{KIND_REGISTER,  7'd0,   32'd1,   48'd0,     1'b1, 1'b1, ST_BAD_HANDLE,  7'd0, 48'd0},
    '{KIND_REGISTER,  7'd0,   32'd0,   48'd1,     1'b1, 1'b1, ST_INTERNAL,    7'd0, 48'd0},
    '{KIND_REGISTER,  7'd0,   OWN_MAX, REF_MAX,   1'b0, 1'b1, ST_DENIED,      7'd0, 48'd0},
    '{KIND_REGISTER,  7'd0,   OWN_MAX, REF_MAX,   1'b1, 1'b1, ST_OK,          7'd1, 48'd0},
    '{KIND_REGISTER,  7'd0,   OWN_MAX, 48'd1,     1'b1, 1'b1, ST_OK,          7'd2, 48'd0},
    '{KIND_REGISTER,  7'h7F,  32'd1,   48'h123,   1'b1, 1'b1, ST_OK,          7'd3, 48'd0},
    '{KIND_LOOKUP_OW, 7'd0,   OWN_MAX, 48'd0,     1'b0, 1'b1, ST_OK,          7'd1, REF_MAX},
    '{KIND_LOOKUP_H,  7'd2,   32'd0,   48'd0,     1'b0, 1'b1, ST_OK,          7'd2, 48'd1},
    '{KIND_LOOKUP_H,  7'h7F,  32'd0,   48'd0,     1'b0, 1'b1, ST_NOT_FOUND,   7'd0, 48'd0},
    '{KIND_RELEASE,   7'd1,   OWN_MAX, 48'd1,     1'b1, 1'b1, ST_NOT_OWNER,   7'd0, 48'd0},
    '{KIND_RELEASE,   7'd1,   32'd1,   REF_MAX,   1'b1, 1'b1, ST_NOT_OWNER,   7'd0, 48'd0},
    // not at the head of the used chain, so the block has to walk it
    '{KIND_RELEASE,   7'd2,   OWN_MAX, 48'd1,     1'b0, 1'b1, ST_OK,          7'd2, 48'd0},
    '{KIND_RELEASE,   7'd3,   32'd1,   48'h123,   1'b1, 1'b1, ST_OK,          7'd3, 48'd0},
    '{KIND_RELEASE,   7'd1,   OWN_MAX, REF_MAX,   1'b1, 1'b1, ST_OK,          7'd1, 48'd0},
    '{KIND_LOOKUP_OW, 7'd0,   OWN_MAX, 48'd0,     1'b0, 1'b1, ST_NOT_FOUND,   7'd0, 48'd0},
    '{KIND_REGISTER,  7'd0,   OWN_A,   48'hAAAA_5555_F00F, 1'b1, 1'b0, ST_OK, 7'd0, 48'd0},
    '{KIND_REGISTER,  7'd0,   OWN_A,   48'h1,     1'b1, 1'b0, ST_OK,          7'd0, 48'd0},
    // two entries share the owner: lowest handle answers
    '{KIND_LOOKUP_OW, 7'd0,   OWN_A,   48'd0,     1'b0, 1'b0, ST_OK,          7'd0, 48'd0},
    '{KIND_RELEASE,   7'd2,   OWN_MAX, 48'd1,     1'b1, 1'b1, ST_WRONG_ORDER, 7'd0, 48'd0}
  };

  function automatic void registry_reset();
    for (int i = 0; i < ENTRIES; i++) begin
      link_of[i]  = (i == 0 || i + 1 >= ENTRIES) ? 0 : i + 1;
      owner_of[i] = '0;
      vmref_of[i] = '0;
      live_of[i]  = 1'b0;
    end
    free_top = 1;
    used_top = 0;
  endfunction

  function automatic void free_push(int unsigned h);
    link_of[h]  = free_top;
    free_top    = h;
    owner_of[h] = '0;
    vmref_of[h] = '0;
    live_of[h]  = 1'b0;
  endfunction

  // take h off the used chain; 0 when the chain is broken
  function automatic bit used_unlink(int unsigned h);
    int unsigned prev;
    int unsigned budget;
    budget = ENTRIES + 2;
    if (link_of[h] >= ENTRIES) return 1'b0;
    if (used_top == h) begin
      used_top = link_of[h];
      return 1'b1;
    end
    prev = used_top;
    while (prev != 0) begin
      if (prev >= ENTRIES) return 1'b0;
      if (budget == 0) return 1'b0;
      budget--;
      if (link_of[prev] == h) break;
      prev = link_of[prev];
    end
    if (prev == 0) return 1'b0;
    link_of[prev] = link_of[h];
    return 1'b1;
  endfunction

  function automatic result_t predict_request(kind_e k, int unsigned h,
                                              logic [OWNER_W-1:0] own,
                                              logic [REF_W-1:0] vr, bit granted);
    result_t     res;
    int unsigned idx;
    res = '{status: ST_OK, handle: '0, vm_ref: '0};
    case (k)
      KIND_REGISTER: begin
        idx = free_top;
        if (idx == 0) begin
          res.status = ST_NO_FREE;
        end else if (vr == '0) begin
          res.status = ST_BAD_HANDLE;
        end else if (own == '0 || idx >= ENTRIES || live_of[idx] || vmref_of[idx] != '0 ||
                     link_of[idx] >= ENTRIES) begin
          res.status = ST_INTERNAL;
        end else if (!granted) begin
          // popped and pushed straight back: both chains end as they were
          res.status = ST_DENIED;
        end else begin
          free_top      = link_of[idx];
          link_of[idx]  = used_top;
          used_top      = idx;
          owner_of[idx] = own;
          vmref_of[idx] = vr;
          live_of[idx]  = 1'b1;
          res.handle    = HANDLE_W'(idx);
        end
      end
      KIND_RELEASE: begin
        if (vr == '0 || h == 0 || h >= ENTRIES) begin
          res.status = ST_BAD_HANDLE;
        end else if (owner_of[h] == '0) begin
          res.status = ST_WRONG_ORDER;
        end else if (vmref_of[h] != vr || owner_of[h] != own) begin
          res.status = ST_NOT_OWNER;
        end else if (!live_of[h] || !used_unlink(h)) begin
          res.status = ST_INTERNAL;
        end else begin
          free_push(h);
          res.handle = HANDLE_W'(h);
        end
      end
      KIND_LOOKUP_H: begin
        if (h == 0 || h >= ENTRIES) begin
          res.status = ST_BAD_HANDLE;
        end else if (!live_of[h] || owner_of[h] == '0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.handle = HANDLE_W'(h);
          res.vm_ref = vmref_of[h];
        end
      end
      default: begin
        res.status = ST_NOT_FOUND;
        if (own != '0) begin
          for (int i = 1; i < ENTRIES; i++) begin
            if (live_of[i] && owner_of[i] == own) begin
              res.status = ST_OK;
              res.handle = HANDLE_W'(i);
              res.vm_ref = vmref_of[i];
              break;
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t ns result %0d: %s got %0h want %0h", $time, results_seen, what, got,
               want);
  endtask

  // one request transfer; the expectation is queued at the accepting edge
  task automatic send_request(kind_e k, logic [HANDLE_W-1:0] h, logic [OWNER_W-1:0] own,
                              logic [REF_W-1:0] vr, bit g, bit typed, result_t typed_res);
    result_t res;
    @(negedge clk_i);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {g, vr, own, h};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    res = predict_request(k, h, own, vr, g);
    result_q.push_back(typed ? typed_res : res);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= !idle_en || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      results_seen++;
      if (result_q.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, '0);
      end else begin
        want = result_q.pop_front();
        if (m_axis_tdata[2:0] !== want.status)
          report_mismatch("status", m_axis_tdata[2:0], want.status);
        if (m_axis_tdata[9:3] !== want.handle)
          report_mismatch("handle_out", m_axis_tdata[9:3], want.handle);
        if (m_axis_tdata[57:10] !== want.vm_ref)
          report_mismatch("vm_ref_out", m_axis_tdata[57:10], want.vm_ref);
      end
    end
  end

  // counts cycles without any transfer on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready === 1'b1) || (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    mix_e                mix;
    int unsigned         r;
    int unsigned         reg_cut;
    int unsigned         rel_cut;
    int unsigned         look_cut;
    int unsigned         live_h [$];
    kind_e               k;
    logic [HANDLE_W-1:0] h;
    logic [OWNER_W-1:0]  own;
    logic [REF_W-1:0]    vr;
    bit                  g;
    row_t                row;

    registry_reset();
    mix = MIX_FILL;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int n = 0; n < NUM_ROWS; n++) begin
      row = directed_rows[n];
      send_request(row.kind, row.hnd, row.own, row.vr, row.grant, row.typed,
                   '{status: row.st, handle: row.h_out, vm_ref: row.r_out});
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // fill to exhaustion first, then drain, then mixed phases
      if (i == 220) begin
        mix = MIX_DRAIN;
      end else if (i == 380) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge clk_i);
        mix = MIX_EVEN;
      end else if (i > 380 && i % 80 == 0) begin
        mix = mix_e'($urandom_range(2));
      end
      idle_en = !(i >= 450 && i < 600);

      case (mix)
        MIX_FILL:  begin reg_cut = 80; rel_cut = 85; end
        MIX_DRAIN: begin reg_cut = 15; rel_cut = 70; end
        default:   begin reg_cut = 35; rel_cut = 65; end
      endcase
      look_cut = rel_cut + (100 - rel_cut) / 2;

      live_h = {};
      for (int j = 1; j < ENTRIES; j++)
        if (live_of[j]) live_h.push_back(j);

      r   = $urandom_range(99);
      own = owner_pool[$urandom_range(7)];
      vr  = REF_W'({$urandom(), $urandom()});
      h   = HANDLE_W'($urandom_range(127));
      g   = ($urandom_range(9) != 0);

      if (r < reg_cut) begin
        k = KIND_REGISTER;
        case ($urandom_range(19))
          0: vr = '0;
          1: own = '0;
          2: own = $urandom();
          default: ;
        endcase
      end else if (r < rel_cut) begin
        k = KIND_RELEASE;
        if (live_h.size() != 0 && $urandom_range(99) < 85) begin
          h   = HANDLE_W'(live_h[$urandom_range(live_h.size() - 1)]);
          own = owner_of[h];
          vr  = vmref_of[h];
        end else begin
          case ($urandom_range(3))
            0: vr = '0;
            1: h = '0;
            2: if (live_h.size() != 0) begin
              // right handle, likely foreign owner and reference
              h = HANDLE_W'(live_h[$urandom_range(live_h.size() - 1)]);
            end
            default: ;
          endcase
        end
      end else if (r < look_cut) begin
        k = KIND_LOOKUP_H;
        if (live_h.size() != 0 && $urandom_range(99) < 70)
          h = HANDLE_W'(live_h[$urandom_range(live_h.size() - 1)]);
      end else begin
        k = KIND_LOOKUP_OW;
        case ($urandom_range(9))
          0: own = '0;
          1: own = $urandom();
          default: ;
        endcase
      end
      send_request(k, h, own, vr, g, 1'b0, '0);
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: handle_free_list_registry_top.f
hdl/hflr_pkg.sv
hdl/hflr_ram.sv
hdl/handle_free_list_registry_top.sv
dv/handle_free_list_registry_top_tb.sv
